### design/sed_pkg.sv
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types, character codes and helpers for the string escape decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sed_pkg;

    // character codes
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // most decoded bytes one raw byte can release
    localparam int unsigned MAX_OUT = 4;

    // escape decoding phase
    typedef enum logic [1:0] {
        PH_TEXT = 2'd0,  // plain text
        PH_ESC  = 2'd1,  // after a backslash
        PH_HEX1 = 2'd2,  // after backslash and x
        PH_HEX2 = 2'd3   // after backslash, x and one hex digit
    } t_phase;

    // result of decoding one raw byte
    typedef struct packed {
        logic [2:0]                 cnt;
        logic [MAX_OUT-1:0][7:0]    bytes;
        t_phase                     phase;
        logic [7:0]                 held;
    } t_dec;

    // hex digit value, bit 4 set when the byte is not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = {1'b0, c[3:0] + 4'd9};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

### design/sed_decode.sv
// ----------------------------------------------------------------------------
// sed_decode
// Decodes one raw byte against the current escape phase: the bytes it
// releases (zero to four) and the next phase and held digit.
// ----------------------------------------------------------------------------
`default_nettype none

module sed_decode import sed_pkg::*; (
    input  wire t_phase     i_phase,
    input  wire logic [7:0] i_held,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    output t_dec            o_dec
);

    logic [4:0] w_hex;
    logic [4:0] w_held_hex;

    assign w_hex      = hex_value(i_byte);
    assign w_held_hex = hex_value(i_held);

    always_comb begin
        logic [2:0]              cnt;
        logic [MAX_OUT-1:0][7:0] bytes;
        t_phase                  phase;
        logic [7:0]              held;
        logic                    plain;

        cnt   = 3'd0;
        bytes = '0;
        phase = PH_TEXT;
        held  = i_held;
        plain = 1'b0;

        // per-phase decode, bytes appended in order
        unique case (i_phase)
            PH_TEXT: begin
                plain = 1'b1;
            end
            PH_ESC: begin
                case (i_byte)
                    CH_N: begin
                        bytes[0] = CH_LF;
                        cnt      = 3'd1;
                    end
                    CH_T: begin
                        bytes[0] = CH_TAB;
                        cnt      = 3'd1;
                    end
                    CH_R: begin
                        bytes[0] = CH_CR;
                        cnt      = 3'd1;
                    end
                    CH_BSLASH: begin
                        bytes[0] = CH_BSLASH;
                        cnt      = 3'd1;
                    end
                    CH_QUOTE: begin
                        bytes[0] = CH_QUOTE;
                        cnt      = 3'd1;
                    end
                    CH_ZERO: begin
                        bytes[0] = CH_NUL;
                        cnt      = 3'd1;
                    end
                    CH_X: begin
                        if (i_last) begin
                            bytes[0] = CH_BSLASH;
                            bytes[1] = CH_X;
                            cnt      = 3'd2;
                        end else begin
                            phase = PH_HEX1;
                        end
                    end
                    default: begin
                        // unknown escape: literal backslash, byte read again
                        bytes[0] = CH_BSLASH;
                        cnt      = 3'd1;
                        plain    = 1'b1;
                    end
                endcase
            end
            PH_HEX1: begin
                if (!w_hex[4] && !i_last) begin
                    held  = i_byte;
                    phase = PH_HEX2;
                end else begin
                    bytes[0] = CH_BSLASH;
                    bytes[1] = CH_X;
                    cnt      = 3'd2;
                    plain    = 1'b1;
                end
            end
            PH_HEX2: begin
                if (!w_hex[4]) begin
                    bytes[0] = {w_held_hex[3:0], w_hex[3:0]};
                    cnt      = 3'd1;
                end else begin
                    bytes[0] = CH_BSLASH;
                    bytes[1] = CH_X;
                    bytes[2] = i_held;
                    cnt      = 3'd3;
                    plain    = 1'b1;
                end
                held = '0;
            end
            default: begin
                plain = 1'b1;
            end
        endcase

        // byte read as plain text
        if (plain) begin
            if (i_byte == CH_BSLASH && !i_last) begin
                phase = PH_ESC;
            end else begin
                bytes[cnt[1:0]] = i_byte;
                cnt             = cnt + 3'd1;
                phase           = PH_TEXT;
            end
        end

        // end of literal returns to the reset state
        if (i_last) begin
            phase = PH_TEXT;
            held  = '0;
        end

        o_dec.cnt   = cnt;
        o_dec.bytes = bytes;
        o_dec.phase = phase;
        o_dec.held  = held;
    end

endmodule

`default_nettype wire

### design/string_escape_decoder.sv
// ----------------------------------------------------------------------------
// string_escape_decoder
// Unescapes C-style string literal bodies, one raw byte per input beat and
// one decoded byte per output beat, with a last flag on the final byte.
// ----------------------------------------------------------------------------
// Path: the first decoded byte of an item passes through the input register
// and then the result buffer before it is offered on the output.
// Throughput: one input beat per cycle while each byte releases at most one
// decoded byte and the output is not stalled; a byte that releases more holds
// the input until the single output port drains the result buffer.
// Reset (synchronous, active low): empties both stages, plain-text phase.
`default_nettype none

module string_escape_decoder import sed_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // raw byte channel
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_last,
    // decoded byte channel
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_out_last
);

    // input register
    logic                    r_in_valid;
    logic [7:0]              r_in_byte;
    logic                    r_in_last;

    // escape state
    t_phase                  r_phase;
    logic [7:0]              r_held;

    // result buffer
    logic [MAX_OUT-1:0][7:0] r_buf;
    logic [2:0]              r_rem;
    logic [1:0]              r_idx;
    logic                    r_last;

    t_dec                    w_dec;
    logic                    w_out_fire;
    logic                    w_buf_free;
    logic                    w_load;
    logic                    w_in_fire;

    sed_decode u_decode (
        .i_phase (r_phase),
        .i_held  (r_held),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_dec   (w_dec)
    );

    // handshakes
    assign w_out_fire = o_valid && !i_stall;
    assign w_buf_free = (r_rem == 3'd0) || ((r_rem == 3'd1) && !i_stall);
    assign w_load     = r_in_valid && w_buf_free;
    assign o_stall    = r_in_valid && !w_buf_free;
    assign w_in_fire  = i_valid && !o_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

    // escape state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TEXT;
            r_held  <= '0;
        end else if (w_load) begin
            r_phase <= w_dec.phase;
            r_held  <= w_dec.held;
        end
    end

    // result buffer: load a decoded group, then drain one byte per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
            r_idx <= '0;
        end else if (w_load) begin
            r_rem <= w_dec.cnt;
            r_idx <= '0;
        end else if (w_out_fire) begin
            r_rem <= r_rem - 3'd1;
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_buf  <= w_dec.bytes;
            r_last <= r_in_last;
        end
    end

    // output beat
    assign o_valid    = (r_rem != 3'd0);
    assign o_out_byte = r_buf[r_idx];
    assign o_out_last = r_last && (r_rem == 3'd1);

    // checks
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= 3'(MAX_OUT))
        else $error("result buffer count out of range");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_in_last) |-> (w_dec.cnt != 3'd0))
        else $error("final raw byte released no decoded byte");

    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_in_last) |=> (r_phase == PH_TEXT && r_held == 8'd0))
        else $error("escape state not cleared at end of literal");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !w_out_fire) |-> !w_load)
        else $error("result buffer overwritten while a beat waits");

endmodule

`default_nettype wire
